>>> hw/rtl/dspc_pkg.sv
package dspc_pkg;

  localparam int PERIOD_W       = 8;
  localparam int VALUE_W        = 16;
  localparam int POS_OUT_W      = 16;
  localparam int POSITION_WIDTH = 16;
  localparam int CFG_IDX_W      = 1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD_AXIS0 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD_AXIS1 = 1'd1;

  typedef enum logic [1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_SET_TARGET = 2'd1,
    FUNC_SET_POS    = 2'd2,
    FUNC_HOME       = 2'd3
  } func_t;

  // per-axis command decoded from one request
  typedef struct packed {
    logic tick;
    logic wr_target;
    logic wr_pos;
    logic home;
  } axis_cmd_t;

  // per-axis pin and status view after a request
  typedef struct packed {
    logic step;
    logic dir;
    logic disabled;
    logic moving;
  } axis_pins_t;

endpackage

>>> hw/rtl/dspc_axis.sv
module dspc_axis
  import dspc_pkg::*;
#(
  parameter int POS_W = POSITION_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  axis_cmd_t               cmd,
  input  logic signed [VALUE_W-1:0] value,
  input  logic [PERIOD_W-1:0]     period,
  output axis_pins_t              pins_nxt,
  output logic signed [POS_W-1:0] pos_nxt
);

  logic [PERIOD_W-1:0]     div_r, div_nxt;
  logic signed [POS_W-1:0] pos_r, tgt_r, tgt_nxt;
  logic                    step_r, step_nxt;
  logic                    dir_r, dir_nxt;
  logic                    dis_r, dis_nxt;
  logic [PERIOD_W:0]       div_inc;
  logic signed [POS_W-1:0] value_ext;

  assign div_inc   = {1'b0, div_r} + 1'b1;
  assign value_ext = POS_W'(value);

  always_comb begin
    div_nxt  = div_r;
    pos_nxt  = pos_r;
    tgt_nxt  = tgt_r;
    step_nxt = step_r;
    dir_nxt  = dir_r;
    dis_nxt  = dis_r;
    if (cmd.tick) begin
      if (period == '0) begin
        div_nxt = div_inc[PERIOD_W-1:0];
      end else if (div_inc < {1'b0, period}) begin
        div_nxt = div_inc[PERIOD_W-1:0];
      end else begin
        // divider at or past the period: restart and act
        div_nxt = '0;
        if (pos_r < tgt_r) begin
          dis_nxt  = 1'b0;
          step_nxt = ~step_r;
          dir_nxt  = 1'b1;
          pos_nxt  = pos_r + POS_W'(1);
        end else if (pos_r > tgt_r) begin
          dis_nxt  = 1'b0;
          step_nxt = ~step_r;
          dir_nxt  = 1'b0;
          pos_nxt  = pos_r - POS_W'(1);
        end else begin
          dis_nxt = 1'b1;
        end
      end
    end
    if (cmd.wr_target) begin
      tgt_nxt = value_ext;
    end
    if (cmd.wr_pos) begin
      pos_nxt = value_ext;
    end
    if (cmd.home) begin
      pos_nxt = '0;
    end
  end

  assign pins_nxt.step     = step_nxt;
  assign pins_nxt.dir      = dir_nxt;
  assign pins_nxt.disabled = dis_nxt;
  assign pins_nxt.moving   = (pos_nxt != tgt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r  <= '0;
      pos_r  <= '0;
      tgt_r  <= '0;
      step_r <= 1'b0;
      dir_r  <= 1'b0;
      dis_r  <= 1'b0;
    end else if (go) begin
      div_r  <= div_nxt;
      pos_r  <= pos_nxt;
      tgt_r  <= tgt_nxt;
      step_r <= step_nxt;
      dir_r  <= dir_nxt;
      dis_r  <= dis_nxt;
    end
  end

endmodule

>>> hw/rtl/dual_stepper_position_controller_core.sv
// Two-axis step/direction position controller. Each request is one of: a tick for both
// axes, a new target, an overwritten position, or a home event (position to zero) for the
// addressed axis, and each request returns exactly one result with both axes' step,
// direction and active-low enable pins, positions and moving flags as they stand after it.
// An axis acts once its tick divider reaches its step period (period 0 never steps):
// short of target it enables the driver, toggles step and moves one position; at target
// it disables the driver. One request is taken every clock cycle unless the pipeline is
// stalled; a request lands in the input register, and as it moves on the axis units and
// the result register update together, so a stalled result only stops the input side
// once both registers are full. The user must write step periods through the
// configuration port (index 0 axis 0, index 1 axis 1, reset 100) only while no request
// is in flight; the block itself does not enforce this. The port is always ready.
module dual_stepper_position_controller_core
  import dspc_pkg::*;
#(
  parameter int POSITION_WIDTH_P = POSITION_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_func,
  input  logic                     in_axis,
  input  logic signed [VALUE_W-1:0] in_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_step_level0,
  output logic                     out_direction0,
  output logic                     out_disabled0,
  output logic                     out_step_level1,
  output logic                     out_direction1,
  output logic                     out_disabled1,
  output logic signed [POS_OUT_W-1:0] out_position0,
  output logic signed [POS_OUT_W-1:0] out_position1,
  output logic                     out_moving0,
  output logic                     out_moving1,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [PERIOD_W-1:0]      cfg_data
);

  // step period registers
  logic [PERIOD_W-1:0] period0_r, period1_r;

  // input register stage
  logic                      s1_valid_r;
  func_t                     s1_func_r;
  logic                      s1_axis_r;
  logic signed [VALUE_W-1:0] s1_value_r;
  logic                      s1_move;

  // result register stage
  logic                        out_valid_r;
  axis_pins_t                  pins0_r, pins1_r;
  logic signed [POS_OUT_W-1:0] pos0_r, pos1_r;

  axis_cmd_t                          cmd0, cmd1;
  axis_pins_t                         pins0_nxt, pins1_nxt;
  logic signed [POSITION_WIDTH_P-1:0] pos0_nxt, pos1_nxt;

  // the input register drains whenever the result register is free or being taken
  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period0_r <= PERIOD_RESET;
      period1_r <= PERIOD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STEP_PERIOD_AXIS0: period0_r <= cfg_data;
        CFG_STEP_PERIOD_AXIS1: period1_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func_r  <= func_t'(in_func);
      s1_axis_r  <= in_axis;
      s1_value_r <= in_value;
    end
  end

  // decode the request into per-axis commands; axis field ignored on a tick
  always_comb begin
    cmd0 = '0;
    cmd1 = '0;
    case (s1_func_r)
      FUNC_TICK: begin
        cmd0.tick = 1'b1;
        cmd1.tick = 1'b1;
      end
      FUNC_SET_TARGET: begin
        cmd0.wr_target = !s1_axis_r;
        cmd1.wr_target = s1_axis_r;
      end
      FUNC_SET_POS: begin
        cmd0.wr_pos = !s1_axis_r;
        cmd1.wr_pos = s1_axis_r;
      end
      FUNC_HOME: begin
        cmd0.home = !s1_axis_r;
        cmd1.home = s1_axis_r;
      end
      default: ;
    endcase
  end

  dspc_axis #(.POS_W(POSITION_WIDTH_P)) u_axis0 (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (s1_move),
    .cmd      (cmd0),
    .value    (s1_value_r),
    .period   (period0_r),
    .pins_nxt (pins0_nxt),
    .pos_nxt  (pos0_nxt)
  );

  dspc_axis #(.POS_W(POSITION_WIDTH_P)) u_axis1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (s1_move),
    .cmd      (cmd1),
    .value    (s1_value_r),
    .period   (period1_r),
    .pins_nxt (pins1_nxt),
    .pos_nxt  (pos1_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // positions leave as their low bits, zero-filled when narrower than the port
  always_ff @(posedge clk) begin
    if (s1_move) begin
      pins0_r <= pins0_nxt;
      pins1_r <= pins1_nxt;
      pos0_r  <= POS_OUT_W'($unsigned(pos0_nxt));
      pos1_r  <= POS_OUT_W'($unsigned(pos1_nxt));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_step_level0 = pins0_r.step;
  assign out_direction0  = pins0_r.dir;
  assign out_disabled0   = pins0_r.disabled;
  assign out_moving0     = pins0_r.moving;
  assign out_step_level1 = pins1_r.step;
  assign out_direction1  = pins1_r.dir;
  assign out_disabled1   = pins1_r.disabled;
  assign out_moving1     = pins1_r.moving;
  assign out_position0   = pos0_r;
  assign out_position1   = pos1_r;

endmodule

>>> hw/rtl/dspc_checker.sv
module dspc_checker
  import dspc_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_step_level0,
  input logic                      out_direction0,
  input logic                      out_disabled0,
  input logic                      out_step_level1,
  input logic                      out_direction1,
  input logic                      out_disabled1,
  input logic signed [POS_OUT_W-1:0] out_position0,
  input logic signed [POS_OUT_W-1:0] out_position1,
  input logic                      out_moving0,
  input logic                      out_moving1,
  input logic                      cfg_valid,
  input logic                      cfg_ready
);

  logic [2*POS_OUT_W+7:0] out_bundle;

  assign out_bundle = {out_step_level0, out_direction0, out_disabled0, out_moving0,
                       out_step_level1, out_direction1, out_disabled1, out_moving1,
                       out_position0, out_position1};

  // no result may appear straight out of reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds, payload unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bundle))
    else $error("stalled result dropped or changed");

  // with the result register empty the input side never stalls
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request stalled with empty result register");

  // configuration writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write held off");

endmodule

bind dual_stepper_position_controller_core dspc_checker u_dspc_checker (.*);

>>> verif/dual_stepper_position_controller_core_test.sv
`timescale 1ns / 1ps

module dual_stepper_position_controller_core_test;
  import dspc_pkg::*;

  localparam int RUN_LIMIT = 400_000;
  localparam int HOLD_OFF_CYCLES = 60;

  // pins and positions of both axes after one request
  // field order: axis 0 pins, axis 1 pins, positions, moving flags
  typedef struct packed {
    logic                        step0;
    logic                        dir0;
    logic                        dis0;
    logic                        step1;
    logic                        dir1;
    logic                        dis1;
    logic signed [POS_OUT_W-1:0] pos0;
    logic signed [POS_OUT_W-1:0] pos1;
    logic                        mov0;
    logic                        mov1;
  } axis_report_t;

  // one line of the directed script: a request or a period write
  typedef struct packed {
    logic                      is_cfg;
    func_t                     func;
    logic                      axis;
    logic signed [VALUE_W-1:0] value;
    logic                      typed;
    axis_report_t              want;
  } script_row_t;

  // receiver back-pressure patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_COMB
  } rx_pattern_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_func = 2'b00;
  logic                      in_axis = 1'b0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_step_level0;
  logic                      out_direction0;
  logic                      out_disabled0;
  logic                      out_step_level1;
  logic                      out_direction1;
  logic                      out_disabled1;
  logic signed [POS_OUT_W-1:0] out_position0;
  logic signed [POS_OUT_W-1:0] out_position1;
  logic                      out_moving0;
  logic                      out_moving1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [PERIOD_W-1:0]       cfg_data = '0;

  // mirror of the controller: periods, dividers, positions, targets and pins
  logic [PERIOD_W-1:0]        step_period [2];
  logic [PERIOD_W-1:0]        tick_count [2];
  logic signed [POS_OUT_W-1:0] axis_pos [2];
  logic signed [POS_OUT_W-1:0] axis_target [2];
  logic                       step_lvl [2];
  logic                       dir_lvl [2];
  logic                       drv_off [2];

  axis_report_t pending_reports [$];
  script_row_t  script [$];
  axis_report_t seen_report;
  axis_report_t due_report;

  int          error_count = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          rx_cycle = 0;
  int          hold_left = 0;
  logic        hold_off_request = 1'b0;
  rx_pattern_t rx_pattern = RX_OPEN;

  dual_stepper_position_controller_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_axis         (in_axis),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_step_level0 (out_step_level0),
    .out_direction0  (out_direction0),
    .out_disabled0   (out_disabled0),
    .out_step_level1 (out_step_level1),
    .out_direction1  (out_direction1),
    .out_disabled1   (out_disabled1),
    .out_position0   (out_position0),
    .out_position1   (out_position1),
    .out_moving0     (out_moving0),
    .out_moving1     (out_moving1),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // works out the pins and positions after one request and updates the mirror
  function automatic axis_report_t apply_request(func_t f, logic ax,
                                                 logic signed [VALUE_W-1:0] v);
    logic [PERIOD_W:0] nxt;
    int                a;
    axis_report_t      r;
    case (f)
      FUNC_TICK: begin
        // the axis field plays no part on a tick
        for (a = 0; a < 2; a++) begin
          nxt = {1'b0, tick_count[a]} + 1'b1;
          if (step_period[a] == '0) begin
            // zero period: divider keeps counting and wraps, axis stays put
            tick_count[a] = nxt[PERIOD_W-1:0];
          end else if (nxt < {1'b0, step_period[a]}) begin
            tick_count[a] = nxt[PERIOD_W-1:0];
          end else begin
            // reached or passed the period, also after the period was lowered
            tick_count[a] = '0;
            if (axis_pos[a] < axis_target[a]) begin
              drv_off[a]  = 1'b0;
              step_lvl[a] = ~step_lvl[a];
              dir_lvl[a]  = 1'b1;
              axis_pos[a] = axis_pos[a] + 1'b1;
            end else if (axis_pos[a] > axis_target[a]) begin
              drv_off[a]  = 1'b0;
              step_lvl[a] = ~step_lvl[a];
              dir_lvl[a]  = 1'b0;
              axis_pos[a] = axis_pos[a] - 1'b1;
            end else begin
              drv_off[a] = 1'b1;
            end
          end
        end
      end
      FUNC_SET_TARGET: axis_target[ax] = v;
      FUNC_SET_POS:    axis_pos[ax] = v;
      default:         axis_pos[ax] = '0; // homing keeps the target
    endcase
    r.step0 = step_lvl[0];
    r.dir0  = dir_lvl[0];
    r.dis0  = drv_off[0];
    r.step1 = step_lvl[1];
    r.dir1  = dir_lvl[1];
    r.dis1  = drv_off[1];
    r.pos0  = axis_pos[0];
    r.pos1  = axis_pos[1];
    r.mov0  = (axis_pos[0] != axis_target[0]);
    r.mov1  = (axis_pos[1] != axis_target[1]);
    return r;
  endfunction

  function automatic void req_row(func_t f, logic ax, logic signed [VALUE_W-1:0] v,
                                  logic typed, axis_report_t want);
    script_row_t row;
    row.is_cfg = 1'b0;
    row.func   = f;
    row.axis   = ax;
    row.value  = v;
    row.typed  = typed;
    row.want   = want;
    script.push_back(row);
  endfunction

  function automatic void cfg_row(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] data);
    script_row_t row;
    row.is_cfg = 1'b1;
    row.func   = FUNC_TICK;
    row.axis   = idx;
    row.value  = {{(VALUE_W-PERIOD_W){1'b0}}, data};
    row.typed  = 1'b0;
    row.want   = '0;
    script.push_back(row);
  endfunction

  // bursts of back-to-back requests with random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // offer one request and hold it until taken
  task automatic send_request(func_t f, logic ax, logic signed [VALUE_W-1:0] v,
                              logic typed, axis_report_t want);
    axis_report_t predicted;
    predicted = apply_request(f, ax, v);
    pending_reports.push_back(typed ? want : predicted);
    in_valid  <= 1'b1;
    cfg_valid <= 1'b0;
    in_func   <= f;
    in_axis   <= ax;
    in_value  <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering until every pending result is back
  task automatic drain_results();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  // valid is left high so a following write keeps it up without a dip
  task automatic write_period(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    step_period[idx] = data;
  endtask

  // result side: compare each result with the oldest prediction, then pick the
  // next ready level from the current stall pattern or a long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      seen_report = {out_step_level0, out_direction0, out_disabled0,
                     out_step_level1, out_direction1, out_disabled1,
                     out_position0, out_position1, out_moving0, out_moving1};
      if (pending_reports.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("result %0d arrived with nothing pending: %h", results_seen, seen_report);
      end else begin
        due_report = pending_reports.pop_front();
        if (seen_report !== due_report) begin
          error_count++;
          if (error_count <= 10) begin
            $display("result %0d mismatch", results_seen);
            $display("  expected step %b%b dir %b%b dis %b%b pos %0d %0d moving %b%b",
                     due_report.step0, due_report.step1, due_report.dir0, due_report.dir1,
                     due_report.dis0, due_report.dis1, due_report.pos0, due_report.pos1,
                     due_report.mov0, due_report.mov1);
            $display("  actual   step %b%b dir %b%b dis %b%b pos %0d %0d moving %b%b",
                     seen_report.step0, seen_report.step1, seen_report.dir0,
                     seen_report.dir1, seen_report.dis0, seen_report.dis1,
                     seen_report.pos0, seen_report.pos1, seen_report.mov0,
                     seen_report.mov1);
          end
        end
      end
    end

    rx_cycle++;
    if (rx_cycle % 48 == 0) rx_pattern = rx_pattern_t'($urandom_range(0, 3));
    if (hold_off_request) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_off_request = 1'b0;
    end
    if (hold_left > 0) begin
      // long hold-off so the pipeline fills and the request side stalls
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_pattern)
        RX_OPEN:  out_ready <= 1'b1;
        RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: out_ready <= ($urandom_range(0, 1) != 0);
        default:  out_ready <= (rx_cycle % 5 < 2);
      endcase
    end
  end

  initial begin
    int                        ph;
    int                        i;
    int                        n;
    int                        tick_pct;
    int                        r;
    func_t                     f;
    logic                      ax;
    logic signed [VALUE_W-1:0] v;
    logic signed [POS_OUT_W-1:0] base;
    logic [PERIOD_W-1:0]       p0;
    logic [PERIOD_W-1:0]       p1;

    // mirror starts from the reset state
    for (i = 0; i < 2; i++) begin
      step_period[i] = PERIOD_RESET;
      tick_count[i]  = '0;
      axis_pos[i]    = '0;
      axis_target[i] = '0;
      step_lvl[i]    = 1'b0;
      dir_lvl[i]     = 1'b0;
      drv_off[i]     = 1'b0;
    end

    // directed script; typed rows read straight off the reset state
    // tick at reset period: nothing acts, drivers enabled, all zero
    req_row(FUNC_TICK, 1'b0, 16'sh0000, 1'b1, {3'b000, 3'b000, 16'sh0000, 16'sh0000, 2'b00});
    // targets at both extremes
    req_row(FUNC_SET_TARGET, 1'b0, 16'sh7fff, 1'b1,
            {3'b000, 3'b000, 16'sh0000, 16'sh0000, 2'b10});
    req_row(FUNC_SET_TARGET, 1'b1, 16'sh8000, 1'b1,
            {3'b000, 3'b000, 16'sh0000, 16'sh0000, 2'b11});
    // positions overwritten with the extremes
    req_row(FUNC_SET_POS, 1'b0, 16'sh8000, 1'b1,
            {3'b000, 3'b000, 16'sh8000, 16'sh0000, 2'b11});
    req_row(FUNC_SET_POS, 1'b1, 16'sh7fff, 1'b1,
            {3'b000, 3'b000, 16'sh8000, 16'sh7fff, 2'b11});
    // homing clears the position only, axis 1 still short of its target
    req_row(FUNC_HOME, 1'b1, 16'sh0000, 1'b1,
            {3'b000, 3'b000, 16'sh8000, 16'sh0000, 2'b11});
    // tick with a stray axis and value
    req_row(FUNC_TICK, 1'b1, 16'shffff, 1'b0, '0);
    // fastest period on axis 0, zero period on axis 1
    cfg_row(CFG_STEP_PERIOD_AXIS0, 8'd1);
    cfg_row(CFG_STEP_PERIOD_AXIS1, 8'd0);
    req_row(FUNC_TICK, 1'b0, 16'sh0000, 1'b0, '0);
    req_row(FUNC_TICK, 1'b0, 16'sh0000, 1'b0, '0);
    // turn axis 0 round, walk it back to the bottom and let it settle
    req_row(FUNC_SET_TARGET, 1'b0, 16'sh8000, 1'b0, '0);
    req_row(FUNC_TICK, 1'b0, 16'sh0000, 1'b0, '0);
    req_row(FUNC_TICK, 1'b0, 16'sh0000, 1'b0, '0);
    req_row(FUNC_TICK, 1'b0, 16'sh0000, 1'b0, '0);
    req_row(FUNC_HOME, 1'b0, 16'sh0000, 1'b0, '0);
    // slowest period on axis 0, axis 1 released at period 1
    cfg_row(CFG_STEP_PERIOD_AXIS0, 8'd255);
    cfg_row(CFG_STEP_PERIOD_AXIS1, 8'd1);
    req_row(FUNC_TICK, 1'b0, 16'sh0000, 1'b0, '0);
    req_row(FUNC_SET_TARGET, 1'b0, 16'sh0003, 1'b0, '0);
    req_row(FUNC_TICK, 1'b0, 16'sh0000, 1'b0, '0);
    req_row(FUNC_TICK, 1'b0, 16'sh0000, 1'b0, '0);
    // period dropped under the divider: next tick restarts and steps
    cfg_row(CFG_STEP_PERIOD_AXIS0, 8'd2);
    req_row(FUNC_TICK, 1'b0, 16'sh0000, 1'b0, '0);
    req_row(FUNC_SET_POS, 1'b1, 16'shaaaa, 1'b0, '0);
    req_row(FUNC_SET_TARGET, 1'b1, 16'sh5555, 1'b0, '0);
    req_row(FUNC_TICK, 1'b1, 16'sh0000, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain_results();
        write_period(script[i].axis, script[i].value[PERIOD_W-1:0]);
      end else begin
        pace_sender();
        send_request(script[i].func, script[i].axis, script[i].value,
                     script[i].typed, script[i].want);
      end
    end

    // random phases, each under its own pair of periods
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       begin p0 = 8'd1;   p1 = 8'd1;   n = 80;  tick_pct = 60; end
        1:       begin p0 = 8'd0;   p1 = 8'd2;   n = 80;  tick_pct = 60; end
        // long tick run so zero-period dividers wrap
        2:       begin p0 = 8'd0;   p1 = 8'd0;   n = 260; tick_pct = 96; end
        3:       begin p0 = 8'd255; p1 = 8'd1;   n = 80;  tick_pct = 60; end
        4:       begin p0 = 8'd2;   p1 = 8'd255; n = 60;  tick_pct = 55; end
        default: begin
          p0 = PERIOD_W'($urandom_range(1, 4));
          p1 = PERIOD_W'($urandom_range(1, 4));
          n = 60;
          tick_pct = 65;
        end
      endcase
      drain_results();
      write_period(CFG_STEP_PERIOD_AXIS0, p0);
      write_period(CFG_STEP_PERIOD_AXIS1, p1);

      for (i = 0; i < n; i++) begin
        if ((ph == 0 && i == 20) || (ph == 4 && i == 30)) hold_off_request = 1'b1;
        if (ph == 5 && i == 40) drain_results();

        ax = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < tick_pct) begin
          f = FUNC_TICK;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 45) f = FUNC_SET_TARGET;
          else if (r < 80) f = FUNC_SET_POS;
          else f = FUNC_HOME;
        end

        // mostly small moves near where the axis is, so it reaches and rests
        base = (f == FUNC_SET_POS) ? axis_target[ax] : axis_pos[ax];
        r = $urandom_range(0, 19);
        if (r < 14) begin
          v = base + VALUE_W'($urandom_range(0, 24)) - VALUE_W'(12);
        end else if (r < 17) begin
          v = VALUE_W'($urandom);
        end else begin
          case ($urandom_range(0, 3))
            0:       v = 16'sh7fff;
            1:       v = 16'sh8000;
            2:       v = 16'sh0000;
            default: v = 16'shffff;
          endcase
        end

        pace_sender();
        send_request(f, ax, v, 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
